// File: hdl/polymul_pkg.sv
// Shared types, widths and codes for the polynomial multiplier.
`default_nettype none
package polymul_pkg;

  localparam int MAX_DEGREE_DEF = 31;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 5;
  localparam int COEF_W = 16;
  localparam int PROD_W = 2 * COEF_W;
  localparam int SUM_W  = 37;
  localparam int DEG_W  = 6;
  localparam int REG_W  = 5;
  localparam int RIDX_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_COMPUTE     = 2'd2
  } op_t;

  localparam logic [RIDX_W-1:0] REG_FIRST_DEGREE  = 1'b0;
  localparam logic [RIDX_W-1:0] REG_SECOND_DEGREE = 1'b1;

  // Tag that travels with each convolution sample through the pipeline.
  typedef struct packed {
    logic             valid;
    logic             is_top;
    logic [DEG_W-1:0] degree;
  } sample_t;

endpackage
`default_nettype wire

// File: hdl/polymul_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module polymul_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/polymul_cell.sv
// One cell of the transposed convolution chain: holds one second-polynomial coefficient.
`default_nettype none
module polymul_cell (
  input  logic                                  clk,
  input  logic                                  advance,
  input  logic                                  clear,
  input  logic                                  load_en,
  input  logic signed [polymul_pkg::COEF_W-1:0] load_value,
  input  logic                                  use_weight,
  input  logic signed [polymul_pkg::COEF_W-1:0] x_in,
  input  logic signed [polymul_pkg::SUM_W-1:0]  sum_in,
  output logic signed [polymul_pkg::SUM_W-1:0]  sum_out
);
  import polymul_pkg::*;

  logic signed [COEF_W-1:0] weight;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load_en) begin
      weight <= load_value;
    end
    if (clear) begin
      prod    <= '0;
      sum_out <= '0;
    end else if (advance) begin
      prod    <= use_weight ? PROD_W'(weight * x_in) : '0;
      sum_out <= sum_in + SUM_W'(prod);
    end
  end

endmodule
`default_nettype wire

// File: hdl/polymul_emit.sv
// Drops zero product terms, marks the highest nonzero term, and holds the output register.
`default_nettype none
module polymul_emit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  polymul_pkg::sample_t                 tag,
  input  logic signed [polymul_pkg::SUM_W-1:0] value,
  output logic                                 free,
  output logic                                 busy,
  output logic                                 term_valid,
  input  logic                                 term_stall,
  output logic [polymul_pkg::DEG_W-1:0]        term_degree,
  output logic signed [polymul_pkg::SUM_W-1:0] term_value,
  output logic                                 is_last
);
  import polymul_pkg::*;

  logic                     pend_valid;
  logic [DEG_W-1:0]         pend_degree;
  logic signed [SUM_W-1:0]  pend_value;
  logic                     done;

  assign free = !term_valid || !term_stall;
  assign busy = pend_valid || done;

  // A nonzero term waits in the pending register until the next nonzero term
  // or the end of the sweep tells whether it is the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (!term_stall) begin
        term_valid <= 1'b0;
      end
      if (free) begin
        if (tag.valid) begin
          if (value != '0) begin
            if (pend_valid) begin
              term_valid  <= 1'b1;
              term_degree <= pend_degree;
              term_value  <= pend_value;
              is_last     <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_degree <= tag.degree;
            pend_value  <= value;
          end
          if (tag.is_top) begin
            done <= 1'b1;
          end
        end else if (done) begin
          done <= 1'b0;
          if (pend_valid) begin
            term_valid  <= 1'b1;
            term_degree <= pend_degree;
            term_value  <= pend_value;
            is_last     <= 1'b1;
            pend_valid  <= 1'b0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/polynomial_multiply_core.sv
// Top level: coefficient store, sample sequencer, cell chain and term emitter.
// A compute item streams da+db+1 samples through the cell chain, one per cycle
// while the output is not stalled; no other item is taken until a compute has
// finished. The chain has MAX_DEGREE+1 multiply cells.
// Reset clears control state and both degree registers; coefficients are undefined until loaded.
`default_nettype none
module polynomial_multiply_core #(
  parameter int MAX_DEGREE = polymul_pkg::MAX_DEGREE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  write_enable,
  input  logic [polymul_pkg::RIDX_W-1:0]        write_index,
  input  logic [polymul_pkg::REG_W-1:0]         write_data,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [polymul_pkg::OP_W-1:0]          operation,
  input  logic [polymul_pkg::IDX_W-1:0]         term_index,
  input  logic signed [polymul_pkg::COEF_W-1:0] coeff_value,
  output logic                                  term_valid,
  input  logic                                  term_stall,
  output logic [polymul_pkg::DEG_W-1:0]         term_degree,
  output logic signed [polymul_pkg::SUM_W-1:0]  term_value,
  output logic                                  is_last
);
  import polymul_pkg::*;

  localparam int N  = MAX_DEGREE + 1;
  localparam int AW = $clog2(N);

  logic [REG_W-1:0] first_degree;
  logic [REG_W-1:0] second_degree;
  logic [IDX_W-1:0] da;
  logic [IDX_W-1:0] db;
  logic [DEG_W-1:0] top;

  logic accept;
  logic load_first;
  logic load_second;
  logic start;
  logic index_ok;

  logic             feeding;
  logic [DEG_W-1:0] count;
  logic             a_live;
  logic             advance;
  logic             emit_busy;

  sample_t s1;
  sample_t s2;
  sample_t s3;
  logic    s1_live;

  logic [AW-1:0]            rd_addr;
  logic signed [COEF_W-1:0] rd_data;
  logic signed [COEF_W-1:0] x;
  logic signed [SUM_W-1:0]  sum_chain [0:N];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_degree  <= '0;
      second_degree <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_FIRST_DEGREE:  first_degree  <= write_data;
        REG_SECOND_DEGREE: second_degree <= write_data;
        default: ;
      endcase
    end
  end

  assign da  = (first_degree > IDX_W'(MAX_DEGREE)) ? IDX_W'(MAX_DEGREE) : first_degree;
  assign db  = (second_degree > IDX_W'(MAX_DEGREE)) ? IDX_W'(MAX_DEGREE) : second_degree;
  assign top = DEG_W'(da) + DEG_W'(db);

  assign item_stall = feeding || s1.valid || s2.valid || s3.valid || emit_busy;
  assign accept     = item_valid && !item_stall;
  assign index_ok   = term_index <= IDX_W'(MAX_DEGREE);

  always_comb begin
    load_first  = 1'b0;
    load_second = 1'b0;
    start       = 1'b0;
    case (operation)
      OP_LOAD_FIRST:  load_first  = accept && index_ok;
      OP_LOAD_SECOND: load_second = accept && index_ok;
      OP_COMPUTE:     start       = accept;
      default: ;
    endcase
  end

  // Sample sequencer: degree n feeds first_coeffs[n] while n <= da, zero after.
  always_ff @(posedge clk) begin
    if (rst) begin
      feeding <= 1'b0;
      count   <= '0;
    end else if (start) begin
      feeding <= 1'b1;
      count   <= '0;
    end else if (feeding && advance) begin
      count <= count + 1'b1;
      if (count == top) begin
        feeding <= 1'b0;
      end
    end
  end

  assign a_live  = count <= DEG_W'(da);
  assign rd_addr = a_live ? count[AW-1:0] : '0;

  polymul_ram #(
    .WIDTH (COEF_W),
    .DEPTH (N)
  ) u_first_store (
    .clk     (clk),
    .wr_en   (load_first),
    .wr_addr (term_index[AW-1:0]),
    .wr_data (coeff_value),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Tags follow the samples: read data, product, and chain output stages.
  // Outside a sweep the chain input is held at zero so no stale sample leaks in.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (advance) begin
      s1.valid <= feeding;
      s2.valid <= s1.valid;
      s3.valid <= s2.valid;
    end
    if (advance) begin
      s1.is_top <= count == top;
      s1.degree <= count;
      s1_live   <= feeding && a_live;
      s2.is_top <= s1.is_top;
      s2.degree <= s1.degree;
      s3.is_top <= s2.is_top;
      s3.degree <= s2.degree;
    end
  end

  assign x = s1_live ? rd_data : '0;

  assign sum_chain[N] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    polymul_cell u_cell (
      .clk        (clk),
      .advance    (advance),
      .clear      (start),
      .load_en    (load_second && (term_index == IDX_W'(k))),
      .load_value (coeff_value),
      .use_weight (db >= IDX_W'(k)),
      .x_in       (x),
      .sum_in     (sum_chain[k+1]),
      .sum_out    (sum_chain[k])
    );
  end

  polymul_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .tag         (s3),
    .value       (sum_chain[0]),
    .free        (advance),
    .busy        (emit_busy),
    .term_valid  (term_valid),
    .term_stall  (term_stall),
    .term_degree (term_degree),
    .term_value  (term_value),
    .is_last     (is_last)
  );

endmodule
`default_nettype wire

// File: bench/polynomial_multiply_core_tb.sv
// Self-checking testbench for polynomial_multiply_core with a built-in convolution predictor.
module polynomial_multiply_core_tb;
  import polymul_pkg::*;

  localparam int COEF_DEPTH = MAX_DEGREE_DEF + 1;
  localparam int SUM_DEPTH = 2 * MAX_DEGREE_DEF + 1;
  localparam int QUIET_LIMIT = 3000;
  localparam int IDLE_PAUSE = 100;
  localparam int LONG_HOLD = 400;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {FROM_MODEL, ONE_TERM, NO_TERMS} check_kind_t;

  typedef struct packed {
    logic [DEG_W-1:0]        degree;
    logic signed [SUM_W-1:0] value;
    logic                    last_term;
  } term_t;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        idx;
    logic [COEF_W-1:0]       val;
    check_kind_t             kind;
    logic [DEG_W-1:0]        degree;
    logic signed [SUM_W-1:0] value;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [RIDX_W-1:0] write_index = '0;
  logic [REG_W-1:0] write_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [OP_W-1:0] operation = '0;
  logic [IDX_W-1:0] term_index = '0;
  logic signed [COEF_W-1:0] coeff_value = '0;
  logic term_valid;
  logic term_stall = 1'b0;
  logic [DEG_W-1:0] term_degree;
  logic signed [SUM_W-1:0] term_value;
  logic is_last;

  // Check instructions that travel with the item being offered.
  check_kind_t row_kind = FROM_MODEL;
  logic [DEG_W-1:0] row_degree = '0;
  logic signed [SUM_W-1:0] row_value = '0;

  // Predictor state.
  logic signed [COEF_W-1:0] first_store [0:COEF_DEPTH-1];
  logic signed [COEF_W-1:0] second_store [0:COEF_DEPTH-1];
  logic [REG_W-1:0] deg_first = '0;
  logic [REG_W-1:0] deg_second = '0;
  term_t fresh_terms[$];
  term_t terms_due[$];

  // Stimulus bookkeeping.
  bit first_loaded [0:COEF_DEPTH-1];
  bit second_loaded [0:COEF_DEPTH-1];
  row_t directed_rows[$];
  bit steady_sender = 1'b0;
  bit long_hold_done = 1'b0;
  int items_sent = 0;
  int computes_accepted = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  polynomial_multiply_core dut (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .operation(operation), .term_index(term_index), .coeff_value(coeff_value),
    .term_valid(term_valid), .term_stall(term_stall),
    .term_degree(term_degree), .term_value(term_value), .is_last(is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Applies one item to the predictor; a compute leaves its nonzero terms in fresh_terms.
  task automatic multiply_terms(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic signed [COEF_W-1:0] val);
    longint sums [0:SUM_DEPTH-1];
    int top;
    int highest;
    term_t t;
    fresh_terms.delete();
    case (op)
      OP_LOAD_FIRST: begin
        first_store[idx] = val;
      end
      OP_LOAD_SECOND: begin
        second_store[idx] = val;
      end
      OP_COMPUTE: begin
        for (int k = 0; k < SUM_DEPTH; k++) sums[k] = 0;
        for (int i = 0; i <= deg_first; i++)
          for (int j = 0; j <= deg_second; j++)
            sums[i + j] += longint'(first_store[i]) * longint'(second_store[j]);
        top = int'(deg_first) + int'(deg_second);
        highest = -1;
        for (int k = 0; k <= top; k++)
          if (sums[k] != 0) highest = k;
        for (int k = 0; k <= top; k++) begin
          if (sums[k] != 0) begin
            t.degree = k[DEG_W-1:0];
            t.value = sums[k][SUM_W-1:0];
            t.last_term = (k == highest);
            fresh_terms.push_back(t);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    term_t t;
    if (!rst) begin
      if (write_enable) begin
        case (write_index)
          REG_FIRST_DEGREE: deg_first = write_data;
          REG_SECOND_DEGREE: deg_second = write_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        multiply_terms(operation, term_index, coeff_value);
        if (operation == OP_COMPUTE) computes_accepted++;
        case (row_kind)
          FROM_MODEL: foreach (fresh_terms[k]) terms_due.push_back(fresh_terms[k]);
          ONE_TERM: terms_due.push_back('{row_degree, row_value, 1'b1});
          default: ;
        endcase
      end
      if (term_valid && !term_stall) begin
        if (terms_due.size() == 0) begin
          report_mismatch("unexpected term, degree", longint'(term_degree), -1);
        end else begin
          t = terms_due.pop_front();
          if (term_degree !== t.degree)
            report_mismatch("term_degree", longint'(term_degree), longint'(t.degree));
          if (term_value !== t.value)
            report_mismatch("term_value", longint'(term_value), longint'(t.value));
          if (is_last !== t.last_term)
            report_mismatch("is_last", longint'(is_last), longint'(t.last_term));
        end
      end
    end
  end

  // The run is stuck if neither channel moves for too long.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (term_valid && !term_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [COEF_W-1:0] random_coeff();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 30) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    return COEF_W'($urandom_range(0, 65535));
  endfunction

  // Offers one item and returns at the edge where it is transferred.
  task automatic offer(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                       input logic [COEF_W-1:0] val, input check_kind_t kind = FROM_MODEL,
                       input logic [DEG_W-1:0] degree = '0,
                       input logic signed [SUM_W-1:0] value = '0);
    int gap;
    gap = steady_sender ? 0 : idle_length();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    term_index <= idx;
    coeff_value <= val;
    row_kind <= kind;
    row_degree <= degree;
    row_value <= value;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (op == OP_LOAD_FIRST) first_loaded[idx] = 1'b1;
    if (op == OP_LOAD_SECOND) second_loaded[idx] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                         input logic [COEF_W-1:0] val, input check_kind_t kind = FROM_MODEL,
                         input logic signed [SUM_W-1:0] value = '0);
    row_t row;
    row.op = op;
    row.idx = idx;
    row.val = val;
    row.kind = kind;
    row.degree = '0;
    row.value = value;
    directed_rows.push_back(row);
  endtask

  // Waits until every expected term has arrived and a compute with no terms has surely ended.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (terms_due.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_degrees(input logic [REG_W-1:0] da, input logic [REG_W-1:0] db);
    write_enable <= 1'b1;
    write_index <= REG_FIRST_DEGREE;
    write_data <= da;
    @(posedge clk);
    write_index <= REG_SECOND_DEGREE;
    write_data <= db;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // A compute must never read a coefficient that was not loaded since reset.
  task automatic load_missing(input int da, input int db);
    for (int i = 0; i <= da; i++)
      if (!first_loaded[i]) offer(OP_LOAD_FIRST, IDX_W'(i), random_coeff());
    for (int i = 0; i <= db; i++)
      if (!second_loaded[i]) offer(OP_LOAD_SECOND, IDX_W'(i), random_coeff());
  endtask

  task automatic compute_now(input int da, input int db);
    load_missing(da, db);
    offer(OP_COMPUTE, IDX_W'($urandom_range(0, 31)), COEF_W'($urandom_range(0, 65535)));
  endtask

  task automatic random_phase(input int da, input int db, input int count);
    int start;
    int r;
    logic [OP_W-1:0] op;
    int limit;
    settle();
    write_degrees(REG_W'(da), REG_W'(db));
    steady_sender = ($urandom_range(0, 3) == 0);
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        offer(OP_UNUSED, IDX_W'($urandom_range(0, 31)), COEF_W'($urandom_range(0, 65535)));
      end else if (r < 72) begin
        op = $urandom_range(0, 1) ? OP_LOAD_SECOND : OP_LOAD_FIRST;
        limit = (op == OP_LOAD_FIRST) ? da : db;
        offer(op, IDX_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, limit)
                                                    : $urandom_range(0, 31)),
              random_coeff());
      end else begin
        compute_now(da, db);
      end
    end
    compute_now(da, db);
    steady_sender = 1'b0;
  endtask

  initial begin
    int run_len;
    int hold_len;
    do @(posedge clk); while (rst);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      term_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      // One long hold while terms are pending fills the block and stalls its input.
      if (!long_hold_done && computes_accepted >= 12 && terms_due.size() > 0) begin
        long_hold_done = 1'b1;
        hold_len = LONG_HOLD;
      end else begin
        hold_len = idle_length();
      end
      if (hold_len > 0) begin
        term_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
    end
  end

  initial begin
    for (int i = 0; i < COEF_DEPTH; i++) begin
      first_loaded[i] = 1'b0;
      second_loaded[i] = 1'b0;
      first_store[i] = '0;
      second_store[i] = '0;
    end

    // Directed rows run with both degrees at zero, so each compute yields at most one term.
    add_row(OP_LOAD_FIRST, 0, 16'h8000);
    add_row(OP_LOAD_SECOND, 0, 16'h8000);
    add_row(OP_COMPUTE, 0, 16'h0000, ONE_TERM, 37'sd1073741824);
    add_row(OP_LOAD_FIRST, 0, 16'h7FFF);
    add_row(OP_COMPUTE, 31, 16'hFFFF, ONE_TERM, -37'sd1073709056);
    add_row(OP_LOAD_SECOND, 0, 16'h0000);
    add_row(OP_COMPUTE, 0, 16'h0000, NO_TERMS);
    add_row(OP_UNUSED, 31, 16'hFFFF);
    add_row(OP_LOAD_SECOND, 0, 16'h0100);
    add_row(OP_LOAD_FIRST, 31, 16'hFFFF);
    add_row(OP_LOAD_SECOND, 31, 16'h7FFF);
    add_row(OP_COMPUTE, 0, 16'h0000, ONE_TERM, 37'sd8388352);
    add_row(OP_LOAD_FIRST, 0, 16'hFFFF);
    add_row(OP_COMPUTE, 0, 16'h0000, ONE_TERM, -37'sd256);
    add_row(OP_UNUSED, 0, 16'h0000);
    add_row(OP_COMPUTE, 0, 16'h0000, ONE_TERM, -37'sd256);
    add_row(OP_LOAD_FIRST, 0, 16'h0001);
    add_row(OP_LOAD_SECOND, 0, 16'hFFFF);
    add_row(OP_COMPUTE, 0, 16'h0000, ONE_TERM, -37'sd1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_degrees(0, 0);
    foreach (directed_rows[k])
      offer(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].val,
            directed_rows[k].kind, directed_rows[k].degree, directed_rows[k].value);

    // Full degrees with every coefficient at the most negative value gives the largest sums.
    settle();
    write_degrees(31, 31);
    for (int i = 0; i < COEF_DEPTH; i++) offer(OP_LOAD_FIRST, IDX_W'(i), 16'h8000);
    for (int i = 0; i < COEF_DEPTH; i++) offer(OP_LOAD_SECOND, IDX_W'(i), 16'h8000);
    offer(OP_COMPUTE, 0, 16'h0000);
    for (int i = 0; i < COEF_DEPTH; i++) offer(OP_LOAD_FIRST, IDX_W'(i), 16'h7FFF);
    offer(OP_COMPUTE, 31, 16'hFFFF);

    random_phase(31, 0, 20);
    random_phase(0, 31, 20);
    random_phase(31, 31, 20);
    for (int p = 0; p < 5; p++) random_phase($urandom_range(0, 6), $urandom_range(0, 6), 20);

    settle();
    if (mismatches == 0 && terms_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/polymul_pkg.sv
hdl/polymul_ram.sv
hdl/polymul_cell.sv
hdl/polymul_emit.sv
hdl/polynomial_multiply_core.sv
bench/polynomial_multiply_core_tb.sv
